// File: src/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  // Reduced results must fit this signed width
  localparam int unsigned VALUE_WIDTH = 32;
  localparam logic [63:0] LIM = 64'd1 << (VALUE_WIDTH - 1);

  // Operation codes
  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;
  localparam logic [2:0] FN_EQ  = 3'd4;
  localparam logic [2:0] FN_LT  = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_COMB, S_GCD, S_GSH, S_DIV, S_CHK, S_DONE
  } state_t;

endpackage

// File: src/rational_arithmetic_unit.sv
// Rational arithmetic unit: bit-serial multiply, binary GCD, bit-serial divide.
//
// Channel   Ports                                  Handshake
// input     in_func, in_a_*, in_b_*                start high, busy low
// result    out_result_*, out_compare_true, ...    out_valid strobe, one cycle
//
// Three 32x32 products are formed one multiplier bit per cycle.
// Reduction runs a binary GCD, one shift or subtract per cycle,
// then two restoring dividers divide numerator and denominator by the GCD.
// Comparison and zero beats finish after the products, error beats at once.
// rst_n is synchronous; the receiver cannot stall the result beat.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_a_numerator,
  input  logic [30:0] in_a_denominator,
  input  logic [31:0] in_b_numerator,
  input  logic [30:0] in_b_denominator,
  output logic        out_valid,
  output logic [31:0] out_result_numerator,
  output logic [30:0] out_result_denominator,
  output logic        out_compare_true,
  output logic [1:0]  out_status
);

  state_t state_r, state_nxt;

  logic [2:0]  func_r;
  logic [31:0] an_r, bn_r;
  logic [30:0] ad_r, bd_r;
  logic [63:0] acc_r, mc_r, p0_r, p1_r, den_r;
  logic [31:0] mp_r;
  logic [5:0]  cnt_r;
  logic [1:0]  idx_r;
  logic [63:0] m_r, u_r, v_r, g_r, ra_r, rb_r, qa_r, qb_r;
  logic        neg_r;
  logic [5:0]  k_r;
  logic [31:0] rn_r;
  logic [30:0] rd_r;
  logic        cmp_r;
  logic [1:0]  status_r;

  // Early decisions straight from the ports
  logic accept, bad_den, div0, unused_fn;
  assign accept    = start && !busy;
  assign bad_den   = (in_func <= FN_LT) &&
                     (in_a_denominator == '0 || in_b_denominator == '0);
  assign div0      = (in_func == FN_DIV) && (in_b_numerator == '0);
  assign unused_fn = (in_func > FN_LT);

  // Magnitudes of the stored numerators
  logic [31:0] abs_an, abs_bn;
  assign abs_an = an_r[31] ? (32'd0 - an_r) : an_r;
  assign abs_bn = bn_r[31] ? (32'd0 - bn_r) : bn_r;

  // Multiplier operands for the next product
  logic [1:0]  ld_idx;
  logic [31:0] mx, my;
  always_comb begin
    unique case (ld_idx)
      2'd0: begin
        mx = abs_an;
        my = (func_r == FN_MUL) ? abs_bn : {1'b0, bd_r};
      end
      2'd1: begin
        mx = abs_bn;
        my = {1'b0, ad_r};
      end
      default: begin
        mx = {1'b0, ad_r};
        my = (func_r == FN_DIV) ? abs_bn : {1'b0, bd_r};
      end
    endcase
  end

  logic [63:0] acc_add;
  assign acc_add = mp_r[0] ? (acc_r + mc_r) : acc_r;

  // Signed combination of the products
  logic signed [64:0] t0, t1, numv;
  logic               neg1, eq_v, lt_v;
  always_comb begin
    t0   = an_r[31] ? -$signed({1'b0, p0_r}) : $signed({1'b0, p0_r});
    neg1 = bn_r[31] ^ (func_r == FN_SUB);
    t1   = neg1 ? -$signed({1'b0, p1_r}) : $signed({1'b0, p1_r});
    if (func_r == FN_ADD || func_r == FN_SUB) begin
      numv = t0 + t1;
    end else begin
      numv = (an_r[31] ^ bn_r[31]) ? -$signed({1'b0, p0_r}) : $signed({1'b0, p0_r});
    end
    eq_v = (t0 == (bn_r[31] ? -$signed({1'b0, p1_r}) : $signed({1'b0, p1_r})));
    lt_v = (t0 <  (bn_r[31] ? -$signed({1'b0, p1_r}) : $signed({1'b0, p1_r})));
  end

  logic is_cmp;
  assign is_cmp = (func_r == FN_EQ) || (func_r == FN_LT);

  // Restoring divide steps
  logic [64:0] sha, shb;
  logic        ga, gb;
  assign sha = {ra_r, qa_r[63]};
  assign shb = {rb_r, qb_r[63]};
  assign ga  = (sha >= {1'b0, g_r});
  assign gb  = (shb >= {1'b0, g_r});

  // Fit test of the reduced result
  logic ovf;
  assign ovf = (qb_r > LIM - 64'd1) || (neg_r ? (qa_r > LIM) : (qa_r > LIM - 64'd1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) begin
        state_nxt = (bad_den || div0 || unused_fn) ? S_DONE : S_MUL;
      end
      S_MUL: if (cnt_r[4:0] == 5'd31 && idx_r == 2'd2) begin
        state_nxt = S_COMB;
      end
      S_COMB: state_nxt = (is_cmp || numv == '0) ? S_DONE : S_GCD;
      S_GCD: if (u_r == v_r) begin
        state_nxt = S_GSH;
      end
      S_GSH: state_nxt = S_DIV;
      S_DIV: if (cnt_r == 6'd63) begin
        state_nxt = S_CHK;
      end
      S_CHK: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy                   = (state_r != S_IDLE);
    out_valid              = (state_r == S_DONE);
    out_result_numerator   = rn_r;
    out_result_denominator = rd_r;
    out_compare_true       = cmp_r;
    out_status             = status_r;
    ld_idx                 = (state_r == S_IDLE) ? 2'd0 : (idx_r + 2'd1);
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (accept) begin
        func_r   <= in_func;
        an_r     <= in_a_numerator;
        ad_r     <= in_a_denominator;
        bn_r     <= in_b_numerator;
        bd_r     <= in_b_denominator;
        rn_r     <= '0;
        rd_r     <= 31'd1;
        cmp_r    <= 1'b0;
        status_r <= (bad_den || div0) ? ST_DIV0 : ST_OK;
        idx_r    <= 2'd3;
        cnt_r    <= 6'd31;
        p0_r     <= '0;
        p1_r     <= '0;
      end
      S_MUL: begin
        acc_r <= acc_add;
        mc_r  <= {mc_r[62:0], 1'b0};
        mp_r  <= {1'b0, mp_r[31:1]};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r[4:0] == 5'd31) begin
          // Latch the finished product, load the next one
          unique case (idx_r)
            2'd0:    p0_r  <= acc_add;
            2'd1:    p1_r  <= acc_add;
            2'd2:    den_r <= acc_add;
            default: ;
          endcase
          idx_r <= ld_idx;
          acc_r <= '0;
          mc_r  <= {32'd0, mx};
          mp_r  <= my;
          cnt_r <= '0;
        end
      end
      S_COMB: begin
        cmp_r <= is_cmp && ((func_r == FN_EQ) ? eq_v : lt_v);
        neg_r <= numv[64];
        m_r   <= numv[64] ? 64'(-numv) : numv[63:0];
        u_r   <= numv[64] ? 64'(-numv) : numv[63:0];
        v_r   <= den_r;
        k_r   <= '0;
      end
      S_GCD: if (u_r != v_r) begin
        // Binary GCD, one move per cycle
        priority if (!u_r[0] && !v_r[0]) begin
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          k_r <= k_r + 6'd1;
        end else if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (u_r > v_r) begin
          u_r <= u_r - v_r;
        end else begin
          v_r <= v_r - u_r;
        end
      end
      S_GSH: begin
        g_r   <= u_r << k_r;
        qa_r  <= m_r;
        qb_r  <= den_r;
        ra_r  <= '0;
        rb_r  <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        ra_r  <= ga ? 64'(sha - {1'b0, g_r}) : sha[63:0];
        rb_r  <= gb ? 64'(shb - {1'b0, g_r}) : shb[63:0];
        qa_r  <= {qa_r[62:0], ga};
        qb_r  <= {qb_r[62:0], gb};
        cnt_r <= cnt_r + 6'd1;
      end
      S_CHK: begin
        if (ovf) begin
          status_r <= ST_OVF;
        end else begin
          rn_r <= neg_r ? (32'd0 - qa_r[31:0]) : qa_r[31:0];
          rd_r <= qb_r[30:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// File: src/rau_checker.sv
// Port-level checks for the rational arithmetic unit, bound to the top level.
module rau_checker
  import rau_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_result_numerator,
  input logic [30:0] out_result_denominator,
  input logic        out_compare_true,
  input logic [1:0]  out_status
);

  // A result beat lasts one cycle
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // An accepted beat makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept without busy");

  // Results appear only while a beat is in hand
  a_vbusy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  // Failed beats and comparisons that hold answer 0/1
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK || out_compare_true) |->
    out_result_numerator == '0 && out_result_denominator == 31'd1)
    else $error("non-zero result with flag");

  // Denominator is never zero
  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_denominator != '0) else $error("zero denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .start                  (start),
  .busy                   (busy),
  .out_valid              (out_valid),
  .out_result_numerator   (out_result_numerator),
  .out_result_denominator (out_result_denominator),
  .out_compare_true       (out_compare_true),
  .out_status             (out_status)
);
